@@ rtl/clex_pkg.sv @@
package clex_pkg;

  // Class of the first byte of the token being built.
  typedef enum logic [1:0] {
    CLS_EMPTY = 2'd0,
    CLS_WORD  = 2'd1,
    CLS_DIGIT = 2'd2,
    CLS_OTHER = 2'd3
  } tok_class_t;

  typedef struct packed {
    logic       in_string;
    logic       in_char_literal;
    tok_class_t first_class;
    logic [1:0] token_length;
  } lex_state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] out_byte;
    logic       starts_token;
  } lex_result_t;

  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_PUNCT_LO   = 8'h21;
  localparam logic [7:0] CH_PUNCT_HI   = 8'h7E;

  localparam logic [1:0] LEN_ZERO  = 2'd0;
  localparam logic [1:0] LEN_SPLIT = 2'd2;
  localparam logic [1:0] LEN_MAX   = 2'd3;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit_byte(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_punct_byte(input logic [7:0] c);
    return c >= CH_PUNCT_LO && c <= CH_PUNCT_HI && !is_letter(c) && !is_digit_byte(c);
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE ||
           c == CH_LBRACKET || c == CH_RBRACKET || c == CH_COMMA;
  endfunction

  function automatic tok_class_t class_of(input logic [7:0] c);
    if (is_letter(c) || c == CH_UNDERSCORE) begin
      return CLS_WORD;
    end else if (is_digit_byte(c)) begin
      return CLS_DIGIT;
    end
    return CLS_OTHER;
  endfunction

endpackage

@@ rtl/clex_step.sv @@
module clex_step import clex_pkg::*; (
  input  logic [7:0]  text_byte,
  input  lex_state_t  state,
  output lex_state_t  state_next,
  output lex_result_t result
);

  always_comb begin
    logic       ins;
    logic       inc;
    tok_class_t cls;
    logic [1:0] len;
    logic       do_close;
    logic       do_emit;
    logic       clear_after;
    logic       fresh;

    ins         = state.in_string;
    inc         = state.in_char_literal;
    cls         = state.first_class;
    len         = state.token_length;
    do_close    = 1'b0;
    do_emit     = 1'b1;
    clear_after = 1'b0;

    // An opening quote ends the current token; a closing quote falls
    // through to the punctuation rules below.
    if (text_byte == CH_DQUOTE && !inc) begin
      if (!ins) begin
        cls = CLS_EMPTY;
        len = LEN_ZERO;
      end
      ins = !ins;
    end
    if (text_byte == CH_SQUOTE && !ins) begin
      if (!inc) begin
        cls = CLS_EMPTY;
        len = LEN_ZERO;
      end
      inc = !inc;
    end

    if (ins || inc) begin
      do_close = 1'b0;
    end else if (text_byte == CH_NEWLINE || is_single(text_byte)) begin
      do_close    = 1'b1;
      clear_after = 1'b1;
    end else if (is_blank(text_byte)) begin
      do_close = 1'b1;
      do_emit  = 1'b0;
    end else if (is_punct_byte(text_byte) && text_byte != CH_UNDERSCORE) begin
      do_close = (len != LEN_ZERO) &&
                 (cls == CLS_WORD || cls == CLS_DIGIT || len == LEN_SPLIT);
    end else if (is_letter(text_byte) || text_byte == CH_UNDERSCORE) begin
      do_close = (cls != CLS_WORD);
    end else if (is_digit_byte(text_byte)) begin
      do_close = (cls != CLS_WORD) && (cls != CLS_DIGIT);
    end

    if (do_close) begin
      cls = CLS_EMPTY;
      len = LEN_ZERO;
    end

    fresh = (len == LEN_ZERO);
    if (do_emit) begin
      if (fresh) begin
        cls = class_of(text_byte);
      end
      if (len != LEN_MAX) begin
        len = len + 2'd1;
      end
    end

    if (clear_after) begin
      cls = CLS_EMPTY;
      len = LEN_ZERO;
    end

    state_next.in_string       = ins;
    state_next.in_char_literal = inc;
    state_next.first_class     = cls;
    state_next.token_length    = len;

    result.emit         = do_emit;
    result.out_byte     = text_byte;
    result.starts_token = fresh;
  end

endmodule

@@ rtl/c_style_lexer_boundary_top.sv @@
// C-style lexer boundary marker.
// Input stream (s_*): one source byte per transfer in s_tdata[7:0].
// Output stream (m_*): one transfer for every byte that is kept, with the
// byte in m_tdata[7:0] and m_tuser high when that byte begins a new token.
// Whitespace other than newline outside string and character literals
// produces no output transfer; it only ends the current token.
// From an input transfer to the matching output transfer, the byte is
// captured in an input register, classified against the lexer state in
// one pass, and written to the output register. Throughput is one byte
// per cycle while the receiver keeps m_tready high; the lexer state that
// every byte reads and writes is updated as the byte leaves the input
// register.
// A synchronous reset clears both pipeline registers and the lexer state
// (no literal open, empty token). When the receiver holds m_tready low, the
// output register keeps its transfer and the input register can still take
// one more byte; s_tready then drops until the output moves on.
module c_style_lexer_boundary_top import clex_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser    // [0] starts_token
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_start;
  lex_state_t  state;
  lex_state_t  state_next;
  lex_result_t result;
  logic        advance;

  clex_step u_step (
    .text_byte  (in_byte),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '{in_string: 1'b0, in_char_literal: 1'b0,
                     first_class: CLS_EMPTY, token_length: LEN_ZERO};
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid && result.emit;
        if (in_valid) begin
          state <= state_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
    if (advance && in_valid && result.emit) begin
      out_byte  <= result.out_byte;
      out_start <= result.starts_token;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tuser  = out_start;

endmodule

@@ rtl/clex_checker.sv @@
module clex_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  // A stalled output transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output transfer changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Reset empties the input register, so the block is ready.
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // With the output register empty there is always room for a byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind c_style_lexer_boundary_top clex_checker u_clex_checker (.*);
